// ===== rtl/dcpid_pkg.sv =====
// Shared constants and types of the dual-channel PID controller.
`timescale 1ns / 1ps

package dcpid_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int INTEGRAL_BITS_DEF = 48;

  localparam int GAIN_W    = 16;
  localparam int DIGIT_W   = 16;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_P_GAIN_LOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_I_GAIN_LOW  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_D_GAIN_LOW  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_P_GAIN_HIGH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_I_GAIN_HIGH = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_D_GAIN_HIGH = 3'd5;

  typedef struct packed {
    logic signed [GAIN_W-1:0] p_low;
    logic signed [GAIN_W-1:0] i_low;
    logic signed [GAIN_W-1:0] d_low;
    logic signed [GAIN_W-1:0] p_high;
    logic signed [GAIN_W-1:0] i_high;
    logic signed [GAIN_W-1:0] d_high;
  } gains_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

endpackage

// ===== rtl/dcpid_regs.sv =====
// APB register file holding the six signed Q8.8 gains.
`timescale 1ns / 1ps

module dcpid_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dcpid_pkg::APB_AW-1:0]     paddr,
  input  logic [dcpid_pkg::APB_DW-1:0]     pwdata,
  output logic [dcpid_pkg::APB_DW-1:0]     prdata,
  output logic                             pready,
  output dcpid_pkg::gains_t                gains_o
);

  dcpid_pkg::gains_t                     gains_q, gains_d;
  logic [dcpid_pkg::REG_IDX_W-1:0]       idx;
  logic                                  wr_en;
  logic signed [dcpid_pkg::GAIN_W-1:0]   wval;
  logic signed [dcpid_pkg::GAIN_W-1:0]   rval;

  assign idx    = paddr[dcpid_pkg::APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign wval   = pwdata[dcpid_pkg::GAIN_W-1:0];
  assign pready = 1'b1;

  always_comb begin
    gains_d = gains_q;
    if (wr_en) begin
      unique case (idx)
        dcpid_pkg::REG_P_GAIN_LOW:  gains_d.p_low  = wval;
        dcpid_pkg::REG_I_GAIN_LOW:  gains_d.i_low  = wval;
        dcpid_pkg::REG_D_GAIN_LOW:  gains_d.d_low  = wval;
        dcpid_pkg::REG_P_GAIN_HIGH: gains_d.p_high = wval;
        dcpid_pkg::REG_I_GAIN_HIGH: gains_d.i_high = wval;
        dcpid_pkg::REG_D_GAIN_HIGH: gains_d.d_high = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dcpid_pkg::REG_P_GAIN_LOW:  rval = gains_q.p_low;
      dcpid_pkg::REG_I_GAIN_LOW:  rval = gains_q.i_low;
      dcpid_pkg::REG_D_GAIN_LOW:  rval = gains_q.d_low;
      dcpid_pkg::REG_P_GAIN_HIGH: rval = gains_q.p_high;
      dcpid_pkg::REG_I_GAIN_HIGH: rval = gains_q.i_high;
      dcpid_pkg::REG_D_GAIN_HIGH: rval = gains_q.d_high;
      default:                    rval = '0;
    endcase
  end

  assign prdata  = {{(dcpid_pkg::APB_DW-dcpid_pkg::GAIN_W){1'b0}}, rval};
  assign gains_o = gains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else begin
      gains_q <= gains_d;
    end
  end

endmodule

// ===== rtl/dcpid_mac.sv =====
// Shared 16 x 17 signed multiplier with a registered product and a shifting accumulator.
`timescale 1ns / 1ps

module dcpid_mac #(
  parameter int SUM_W = 66,
  parameter int SHW   = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dcpid_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [dcpid_pkg::GAIN_W-1:0]   gain_i,
  input  logic signed [dcpid_pkg::DIGIT_W:0]    digit_i,
  input  logic [SHW-1:0]                        shift_i,
  output logic signed [SUM_W-1:0]               sum_o
);

  localparam int PROD_W = dcpid_pkg::GAIN_W + dcpid_pkg::DIGIT_W + 1;

  logic signed [PROD_W-1:0] prod_q;
  logic [SHW-1:0]           shift_q;
  logic                     pvalid_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  addend;

  // The shift is counted in whole digits, so it becomes a multiple of 16 bits.
  assign addend = SUM_W'(prod_q) <<< {shift_q, 4'b0000};
  assign sum_o  = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      pvalid_q <= 1'b0;
    end else begin
      pvalid_q <= ctrl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q  <= gain_i * digit_i;
      shift_q <= shift_i;
    end
    if (ctrl_i.clear) begin
      sum_q <= '0;
    end else if (pvalid_q) begin
      sum_q <= sum_q + addend;
    end
  end

endmodule

// ===== rtl/dual_channel_pid_controller.sv =====
// Top level of the dual-channel PID controller: sequencer, channel state and output beat.
`timescale 1ns / 1ps

// Two-channel discrete PID. Each input beat selects the lower (0) or upper (1) joint and
// carries a target and a measured position; the result beat carries the drive value,
// Kp*e + Ki*integral + Kd*(e - previous e) in Q.24, truncated toward zero and saturated
// to 16-bit signed, where the integral adds e*655 (0.01 in Q.16) with saturation. All
// products go through one 16 x 17 signed multiplier, one 16-bit digit of the operand per
// cycle. An item passes from acceptance through the integral update, the multiply steps,
// a drain state and an output state, and the idle state then takes the next beat; the
// result beat is presented from the output state once the previous result has been taken.
// The block takes no new beat while it works, but it does take one while a finished result
// still waits. Gains must be written over APB only while the block is idle; the block
// itself does not enforce this.
module dual_channel_pid_controller #(
  parameter int POSITION_BITS = dcpid_pkg::POSITION_BITS_DEF,
  parameter int INTEGRAL_BITS = dcpid_pkg::INTEGRAL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dcpid_pkg::APB_AW-1:0]      paddr,
  input  logic [dcpid_pkg::APB_DW-1:0]      pwdata,
  output logic [dcpid_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              channel_i,
  input  logic signed [POSITION_BITS-1:0]   target_position_i,
  input  logic signed [POSITION_BITS-1:0]   measured_position_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [15:0]                drive_value_o
);

  localparam int EW     = POSITION_BITS + 1;
  localparam int DW     = POSITION_BITS + 2;
  localparam int NDP    = (EW + 15) / 16;
  localparam int NDI    = (INTEGRAL_BITS + 15) / 16;
  localparam int NDD    = (DW + 15) / 16;
  localparam int NDMAX  = (NDI > NDD) ? NDI : NDD;
  localparam int PADW   = NDMAX * 16;
  localparam int NSTEP  = NDP + NDI + NDD;
  localparam int STW    = $clog2(NSTEP);
  localparam int KW     = $clog2(NDMAX);
  localparam int SHMAX  = ((NDI - 1) > NDD) ? (NDI - 1) : NDD;
  localparam int SHW    = $clog2(SHMAX + 1);
  localparam int SUM_W  = (((32 + NDD * 16) > (16 + NDI * 16)) ?
                           (32 + NDD * 16) : (16 + NDI * 16)) + 2;
  localparam int QW     = SUM_W - 24;
  localparam int INCW   = POSITION_BITS + 11;
  localparam int SATW   = ((INTEGRAL_BITS > INCW) ? INTEGRAL_BITS : INCW) + 1;

  localparam logic signed [SATW-1:0] IMAX = SATW'({1'b0, {(INTEGRAL_BITS-1){1'b1}}});
  localparam logic signed [SATW-1:0] IMIN = -IMAX - SATW'(1);
  localparam logic signed [QW-1:0]   QMAX = QW'(32767);
  localparam logic signed [QW-1:0]   QMIN = -QMAX - QW'(1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INTEG = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  logic [2:0]                    state_q, state_d;
  logic [STW-1:0]                step_q, step_d;
  logic                          ch_q;
  logic signed [EW-1:0]          e_q;
  logic signed [DW-1:0]          diff_q;
  logic signed [INTEGRAL_BITS-1:0] integ_q [2];
  logic signed [EW-1:0]          prev_q [2];
  logic                          out_valid_q;
  logic signed [15:0]            drive_q;

  dcpid_pkg::gains_t             gains;
  dcpid_pkg::mac_ctrl_t          mac_ctrl;
  logic                          in_accept;
  logic                          out_free;
  logic signed [EW-1:0]          e_in;

  logic signed [INCW-1:0]        ev;
  logic signed [INCW-1:0]        inc;
  logic signed [SATW-1:0]        isum;
  logic signed [INTEGRAL_BITS-1:0] integ_new;

  logic [1:0]                    term;
  logic [STW-1:0]                kfull;
  logic [KW-1:0]                 k;
  logic [KW-1:0]                 k_top;
  logic signed [PADW-1:0]        opnd;
  logic signed [PADW-1:0]        opnd_sh;
  logic [15:0]                   dig16;
  logic signed [16:0]            digit;
  logic signed [15:0]            gain;
  logic [SHW-1:0]                shift;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       adj;
  logic signed [QW-1:0]          qv;
  logic signed [15:0]            drive_d;

  dcpid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains_o (gains)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign e_in        = EW'(target_position_i) - EW'(measured_position_i);

  // Integral step e*655 as shift-and-add: 655 = 512 + 128 + 8 + 4 + 2 + 1.
  assign ev  = INCW'(e_q);
  assign inc = (ev <<< 9) + (ev <<< 7) + (ev <<< 3) + (ev <<< 2) + (ev <<< 1) + ev;
  assign isum = SATW'(integ_q[ch_q]) + SATW'(inc);

  always_comb begin
    priority if (isum > IMAX) begin
      integ_new = INTEGRAL_BITS'(IMAX);
    end else if (isum < IMIN) begin
      integ_new = INTEGRAL_BITS'(IMIN);
    end else begin
      integ_new = INTEGRAL_BITS'(isum);
    end
  end

  // Map the flat step count onto a term and a digit of that term's operand.
  always_comb begin
    priority if (step_q < STW'(NDP)) begin
      term  = TERM_P;
      kfull = step_q;
    end else if (step_q < STW'(NDP + NDI)) begin
      term  = TERM_I;
      kfull = step_q - STW'(NDP);
    end else begin
      term  = TERM_D;
      kfull = step_q - STW'(NDP + NDI);
    end
  end

  assign k = kfull[KW-1:0];

  always_comb begin
    unique case (term)
      TERM_P: begin
        opnd  = PADW'(e_q);
        k_top = KW'(NDP - 1);
        gain  = ch_q ? gains.p_high : gains.p_low;
      end
      TERM_I: begin
        opnd  = PADW'(integ_q[ch_q]);
        k_top = KW'(NDI - 1);
        gain  = ch_q ? gains.i_high : gains.i_low;
      end
      default: begin
        opnd  = PADW'(diff_q);
        k_top = KW'(NDD - 1);
        gain  = ch_q ? gains.d_high : gains.d_low;
      end
    endcase
  end

  // Lower digits are unsigned; only the top digit of an operand carries its sign.
  assign opnd_sh = opnd >>> {k, 4'b0000};
  assign dig16   = opnd_sh[15:0];
  assign digit   = (k == k_top) ? {dig16[15], dig16} : {1'b0, dig16};
  assign shift   = SHW'(k) + ((term == TERM_I) ? SHW'(0) : SHW'(1));

  assign mac_ctrl.clear = in_accept;
  assign mac_ctrl.issue = (state_q == ST_MUL);

  dcpid_mac #(
    .SUM_W (SUM_W),
    .SHW   (SHW)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .gain_i  (gain),
    .digit_i (digit),
    .shift_i (shift),
    .sum_o   (sum)
  );

  // A negative sum is biased up before the shift so the quotient truncates toward zero.
  assign adj = sum + {{(SUM_W-24){1'b0}}, {24{sum[SUM_W-1]}}};
  assign qv  = adj[SUM_W-1:24];

  always_comb begin
    priority if (qv > QMAX) begin
      drive_d = 16'sh7FFF;
    end else if (qv < QMIN) begin
      drive_d = -16'sh8000;
    end else begin
      drive_d = qv[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_INTEG;
        end
      end
      ST_INTEG: begin
        state_d = ST_MUL;
        step_d  = '0;
      end
      ST_MUL: begin
        if (step_q == STW'(NSTEP - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + STW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      integ_q[0]  <= '0;
      integ_q[1]  <= '0;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_INTEG) begin
        integ_q[ch_q] <= integ_new;
        prev_q[ch_q]  <= e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q <= channel_i;
      e_q  <= e_in;
    end
    if (state_q == ST_INTEG) begin
      diff_q <= DW'(e_q) - DW'(prev_q[ch_q]);
    end
    if (state_q == ST_FIN && out_free) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_INTEG))
    else $error("accepted beat did not start the integral update");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (step_q <= STW'(NSTEP - 1)))
    else $error("multiply step counter ran past the last digit");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished item was not presented as a result beat");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result beat appeared without a finished item");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the dual-channel PID controller.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_GAINS = 6;
  localparam int IDX_W = dcpid_pkg::REG_IDX_W;
  localparam int AW = dcpid_pkg::APB_AW;
  localparam int DW = dcpid_pkg::APB_DW;
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic CH_LOWER = 1'b0;
  localparam logic CH_UPPER = 1'b1;
  localparam logic signed [63:0] INTEG_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [63:0] INTEG_MIN = -(64'sd1 <<< 47);
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic               ch;
    logic signed [15:0] tgt;
    logic signed [15:0] mea;
  } joint_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic channel_i = 1'b0;
  logic signed [15:0] target_position_i = '0;
  logic signed [15:0] measured_position_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] drive_value_o;

  dual_channel_pid_controller dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .channel_i, .target_position_i, .measured_position_i,
    .out_valid_o, .out_stall_i, .drive_value_o
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the controller: gains, integrators and previous errors.
  logic signed [15:0] gain_q88 [NUM_GAINS];
  logic signed [63:0] integ_q16 [2];
  logic signed [16:0] prev_err [2];

  joint_sample_t pending_samples [$];
  logic signed [15:0] expected_drive [$];

  int errors_seen = 0;
  int beats_in = 0;
  int drives_checked = 0;
  int settings_used = 0;
  int in_gap_max = 0;
  int out_stall_max = 0;
  int in_gap = 0;
  int out_hold = 0;
  bit in_loaded = 1'b0;
  bit in_took = 1'b0;
  bit out_took = 1'b0;
  joint_sample_t next_beat;

  function automatic logic signed [15:0] next_drive(input logic ch,
                                                    input logic signed [15:0] tgt,
                                                    input logic signed [15:0] mea);
    logic signed [16:0] err;
    logic signed [17:0] derr;
    logic signed [63:0] acc;
    logic signed [95:0] kp_w, ki_w, kd_w, e_w, d_w, a_w, total, mag;
    logic signed [15:0] res;
    err = tgt - mea;
    acc = integ_q16[ch] + err * 64'sd655;
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    else if (acc < INTEG_MIN) acc = INTEG_MIN;
    integ_q16[ch] = acc;
    derr = err - prev_err[ch];
    prev_err[ch] = err;
    kp_w = gain_q88[ch ? dcpid_pkg::REG_P_GAIN_HIGH : dcpid_pkg::REG_P_GAIN_LOW];
    ki_w = gain_q88[ch ? dcpid_pkg::REG_I_GAIN_HIGH : dcpid_pkg::REG_I_GAIN_LOW];
    kd_w = gain_q88[ch ? dcpid_pkg::REG_D_GAIN_HIGH : dcpid_pkg::REG_D_GAIN_LOW];
    e_w = err;
    d_w = derr;
    a_w = acc;
    // Everything lines up in Q.24 before the single truncating shift.
    total = ((kp_w * e_w) <<< 16) + ki_w * a_w + ((kd_w * d_w) <<< 16);
    mag = (total < 0) ? -total : total;
    mag = mag >>> 24;
    if (total < 0) res = (mag > 96'sd32768) ? -16'sd32768 : 16'(-mag);
    else res = (mag > 96'sd32767) ? 16'sd32767 : 16'(mag);
    return res;
  endfunction

  // Acceptance of both channels is observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_drive.push_back(next_drive(channel_i, target_position_i, measured_position_i));
      beats_in++;
      in_took = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_took = 1'b1;
      if (expected_drive.size() == 0) begin
        $error("drive_value beat with nothing expected: got %0d", drive_value_o);
        errors_seen++;
      end else begin
        if (drive_value_o !== expected_drive[0]) begin
          $error("drive_value mismatch: expected %0d, got %0d",
                 expected_drive[0], drive_value_o);
          errors_seen++;
        end
        void'(expected_drive.pop_front());
        drives_checked++;
      end
    end
  end

  // Input driver: a random gap before each beat, payload held until taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_took) begin
        in_took = 1'b0;
        in_loaded = 1'b0;
        in_gap = $urandom_range(0, in_gap_max);
      end
      if (!in_loaded && in_gap == 0 && pending_samples.size() > 0) begin
        next_beat = pending_samples.pop_front();
        channel_i <= next_beat.ch;
        target_position_i <= next_beat.tgt;
        measured_position_i <= next_beat.mea;
        in_valid_i <= 1'b1;
        in_loaded = 1'b1;
      end else if (!in_loaded) begin
        if (in_gap > 0) in_gap--;
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: hold off each result for a random number of cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        out_took = 1'b0;
        out_hold = $urandom_range(0, out_stall_max);
      end
      if (out_hold > 0) begin
        out_stall_i <= 1'b1;
        if (out_valid_o) out_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx < NUM_GAINS) gain_q88[idx] = data[15:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check(input logic [IDX_W-1:0] idx);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== gain_q88[idx]) begin
      $error("gain register %0d readback mismatch: expected %0d, got %0d",
             idx, gain_q88[idx], $signed(prdata[15:0]));
      errors_seen++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Loads all six gains (upper pwdata bits are junk), pokes the unused slots,
  // then reads every gain back.
  task automatic load_gains(input logic [15:0] g [NUM_GAINS]);
    for (int i = 0; i < NUM_GAINS; i++)
      apb_write(IDX_W'(i), {16'($urandom_range(0, 65535)), g[i]});
    apb_write(REG_SPARE_A, $urandom());
    apb_write(REG_SPARE_B, $urandom());
    for (int i = 0; i < NUM_GAINS; i++) apb_check(IDX_W'(i));
    settings_used++;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_loaded || expected_drive.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] draw_gain();
    int sel;
    int mag;
    sel = $urandom_range(0, 7);
    mag = $urandom_range(0, 2047);
    case (sel)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4, 5: return ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic joint_sample_t draw_sample();
    joint_sample_t s;
    int kind;
    s.ch = $urandom_range(0, 1) ? CH_UPPER : CH_LOWER;
    s.tgt = 16'($urandom());
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      // Tracking the target closely, as a running control loop would.
      s.mea = s.tgt + 16'($signed($urandom_range(0, 400)) - 200);
    end else if (kind < 9) begin
      s.mea = 16'($urandom());
    end else begin
      s.tgt = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      s.mea = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end
    return s;
  endfunction

  task automatic push_sample(input logic ch, input int tgt, input int mea);
    joint_sample_t s;
    s.ch = ch;
    s.tgt = 16'(tgt);
    s.mea = 16'(mea);
    pending_samples.push_back(s);
  endtask

  initial begin
    logic [15:0] g [NUM_GAINS];
    for (int i = 0; i < NUM_GAINS; i++) gain_q88[i] = '0;
    integ_q16[0] = '0;
    integ_q16[1] = '0;
    prev_err[0] = '0;
    prev_err[1] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Lower channel at the smallest gain checks truncation toward zero;
    // upper channel at full-scale gains drives into saturation.
    g = '{16'h0001, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF};
    load_gains(g);
    in_gap_max = 2;
    out_stall_max = 2;
    push_sample(CH_LOWER, 0, 1);
    push_sample(CH_LOWER, 1, 0);
    push_sample(CH_LOWER, 32767, -32768);
    push_sample(CH_LOWER, -32768, 32767);
    push_sample(CH_LOWER, 0, 0);
    push_sample(CH_UPPER, 32767, -32768);
    push_sample(CH_UPPER, -32768, 32767);
    push_sample(CH_UPPER, 0, 0);
    push_sample(CH_UPPER, 100, 100);
    push_sample(CH_UPPER, -1, 0);
    wait_drained();

    g = '{16'h8000, 16'h7FFF, 16'h8000, 16'h0100, 16'h0100, 16'h0100};
    load_gains(g);
    push_sample(CH_LOWER, 32767, -32768);
    push_sample(CH_LOWER, -32768, 32767);
    push_sample(CH_LOWER, 5, 7);
    push_sample(CH_UPPER, 10, 0);
    push_sample(CH_UPPER, 10, 0);
    push_sample(CH_UPPER, -10, 0);
    push_sample(CH_UPPER, 0, 0);
    push_sample(CH_UPPER, 32767, -32768);
    push_sample(CH_LOWER, -32768, -32768);
    push_sample(CH_UPPER, -32768, 32767);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      for (int i = 0; i < NUM_GAINS; i++) g[i] = draw_gain();
      load_gains(g);
      in_gap_max = (p % 3 == 0) ? 0 : 13;
      out_stall_max = (p % 4 < 2) ? 13 : 0;
      for (int n = 0; n < 200; n++) pending_samples.push_back(draw_sample());
      wait_drained();
    end

    if (expected_drive.size() != 0) begin
      $error("%0d drive_value beats never arrived", expected_drive.size());
      errors_seen++;
    end
    $display("Sent %0d joint samples under %0d gain settings; checked %0d drive values.",
             beats_in, settings_used, drives_checked);
    if (errors_seen == 0) begin
      $display("PASS dual_channel_pid_controller");
    end else begin
      $display("FAIL dual_channel_pid_controller");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL dual_channel_pid_controller");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dcpid_pkg.sv
rtl/dcpid_regs.sv
rtl/dcpid_mac.sv
rtl/dual_channel_pid_controller.sv
tb/tb.sv
